### src/srd_pkg.sv
// Shared types and constants for the sound request deque.
// No dependencies; compiled first.
package srd_pkg;

  localparam int RING_DEPTH_DEF = 16;
  localparam int CLIP_W         = 16;
  localparam int OP_W           = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd1;
  localparam logic [OP_W-1:0] OP_URGENT = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } srd_state_t;

  typedef struct packed {
    logic exec;   // apply the accepted request to the ring
    logic load;   // move the pending result into the output register
  } srd_cmd_t;

  typedef struct packed {
    logic out_free;
  } srd_sts_t;

endpackage

### src/srd_if.sv
// Request and result channel interfaces for the sound request deque.
// Depends on srd_pkg for field widths.
interface srd_in_if;
  logic                        valid;
  logic                        ready;
  logic [srd_pkg::OP_W-1:0]    op;
  logic [srd_pkg::CLIP_W-1:0]  clip_id;
  logic                        player_busy;

  modport source (output valid, output op, output clip_id, output player_busy, input ready);
  modport sink   (input valid, input op, input clip_id, input player_busy, output ready);
endinterface

interface srd_out_if;
  logic                        valid;
  logic                        ready;
  logic                        play_start;
  logic [srd_pkg::CLIP_W-1:0]  play_clip;
  logic                        play_blank;
  logic                        speaker_on;
  logic                        push_ok;
  logic                        evicted;

  modport source (output valid, output play_start, output play_clip, output play_blank,
                  output speaker_on, output push_ok, output evicted, input ready);
  modport sink   (input valid, input play_start, input play_clip, input play_blank,
                  input speaker_on, input push_ok, input evicted, output ready);
endinterface

### src/sound_request_deque_top.sv
// Sound request deque: ring of clip requests with urgent head insert.
// Depends on srd_pkg, srd_if, srd_ram, srd_ctrl and srd_dp.
//
// Usage:
//   in_req  - request channel (valid/ready): op, clip_id, player_busy.
//             op 0 is a tick, 1 a normal push to the tail, 2 an urgent
//             keypad push to the head; op 3 changes nothing.
//   out_res - one result per request (valid/ready): play_start, play_clip,
//             play_blank, speaker_on, push_ok, evicted.
//   Sequence: a new request is taken only after the previous result has
//   been loaded into the output register; the request is applied in
//   the cycle it is taken, the clip RAM read data is registered and the
//   result is then loaded into the output register once it is free.
//   Stall: a held result does not block the next request being taken;
//   that request's result waits until the output register is taken.
//   Reset: the ring is empty, all marks clear and the speaker off; clip
//   storage is not cleared and needs no clearing pass.
//   The ring holds RING_DEPTH-1 clips.
module sound_request_deque_top #(
  parameter int RING_DEPTH = srd_pkg::RING_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  srd_in_if.sink    in_req,
  srd_out_if.source out_res
);
  import srd_pkg::*;

  srd_cmd_t cmd;
  srd_sts_t sts;
  logic     in_ready;

  assign in_req.ready = in_ready;

  srd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  srd_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_req.op),
    .in_clip_id     (in_req.clip_id),
    .in_player_busy (in_req.player_busy),
    .out_ready      (out_res.ready),
    .out_valid      (out_res.valid),
    .out_play_start (out_res.play_start),
    .out_play_clip  (out_res.play_clip),
    .out_play_blank (out_res.play_blank),
    .out_speaker_on (out_res.speaker_on),
    .out_push_ok    (out_res.push_ok),
    .out_evicted    (out_res.evicted)
  );

endmodule

### src/srd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/srd_ctrl.sv
// Controller for the sound request deque: accepts a request, then waits
// for the output register to free up. Depends on srd_pkg.
module srd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  srd_pkg::srd_sts_t sts,
  output logic              in_ready,
  output srd_pkg::srd_cmd_t cmd
);
  import srd_pkg::*;

  srd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid)     state_nxt = S_LOAD;
      S_LOAD: if (sts.out_free) state_nxt = S_IDLE;
      default:                  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.exec = in_valid;
      end
      S_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### src/srd_dp.sv
// Datapath for the sound request deque: ring pointers, keypad and blank
// marks, clip RAM and output register. Depends on srd_pkg and srd_ram.
module srd_dp #(
  parameter int RING_DEPTH = srd_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  srd_pkg::srd_cmd_t           cmd,
  output srd_pkg::srd_sts_t           sts,
  input  logic [srd_pkg::OP_W-1:0]    in_op,
  input  logic [srd_pkg::CLIP_W-1:0]  in_clip_id,
  input  logic                        in_player_busy,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_play_start,
  output logic [srd_pkg::CLIP_W-1:0]  out_play_clip,
  output logic                        out_play_blank,
  output logic                        out_speaker_on,
  output logic                        out_push_ok,
  output logic                        out_evicted
);
  import srd_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  logic [IDX_W-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic                  speaker_r, speaker_nxt;
  logic [RING_DEPTH-1:0] keypad_r, keypad_nxt, blank_r, blank_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // pending result flags, captured when the request is applied
  logic res_start_r, res_blank_r, res_ok_r, res_ev_r;
  logic res_start, res_blank, res_ok, res_ev;

  logic                  o_start_r, o_blank_r, o_speaker_r, o_ok_r, o_ev_r;
  logic [CLIP_W-1:0]     o_clip_r;

  logic [IDX_W-1:0] head_inc, head_dec, tail_inc, ins_idx, ins_dec;
  logic             ring_empty, ring_full;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [CLIP_W-1:0] ram_rdata;

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    idx_next = (i == IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
    idx_prev = (i == '0) ? IDX_LAST : i - 1'b1;
  endfunction

  assign head_inc   = idx_next(head_r);
  assign head_dec   = idx_prev(head_r);
  assign tail_inc   = idx_next(tail_r);
  assign ring_empty = (tail_r == head_r);
  assign ring_full  = (tail_inc == head_r);
  // urgent insert slot: head moves on first when the ring is full
  assign ins_idx    = ring_full ? head_inc : head_r;
  assign ins_dec    = ring_full ? head_r : head_dec;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    speaker_nxt = speaker_r;
    keypad_nxt  = keypad_r;
    blank_nxt   = blank_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = tail_inc;
    res_start   = 1'b0;
    res_blank   = 1'b0;
    res_ok      = 1'b0;
    res_ev      = 1'b0;
    if (cmd.exec) begin
      unique case (in_op)
        OP_TICK: begin
          if (!in_player_busy) begin
            if (ring_empty) begin
              speaker_nxt = 1'b0;
            end else begin
              head_nxt    = head_inc;
              ram_re      = 1'b1;
              res_start   = 1'b1;
              res_blank   = blank_r[head_inc];
              speaker_nxt = 1'b1;
            end
          end
        end
        OP_PUSH: begin
          if (!ring_full) begin
            tail_nxt             = tail_inc;
            ram_we               = 1'b1;
            ram_waddr            = tail_inc;
            keypad_nxt[tail_inc] = 1'b0;
            blank_nxt[tail_inc]  = 1'b0;
            res_ok               = 1'b1;
          end
        end
        OP_URGENT: begin
          res_ev              = ring_full;
          blank_nxt           = blank_r | keypad_r;
          ram_we              = 1'b1;
          ram_waddr           = ins_idx;
          keypad_nxt[ins_idx] = 1'b1;
          blank_nxt[ins_idx]  = 1'b0;
          head_nxt            = ins_dec;
          res_ok              = 1'b1;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  srd_ram #(
    .WIDTH (CLIP_W),
    .DEPTH (RING_DEPTH)
  ) u_clip_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_clip_id),
    .re    (ram_re),
    .raddr (head_inc),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      speaker_r   <= 1'b0;
      keypad_r    <= '0;
      blank_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      speaker_r   <= speaker_nxt;
      keypad_r    <= keypad_nxt;
      blank_r     <= blank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_start_r <= res_start;
      res_blank_r <= res_blank;
      res_ok_r    <= res_ok;
      res_ev_r    <= res_ev;
    end
    if (cmd.load) begin
      o_start_r   <= res_start_r;
      o_blank_r   <= res_blank_r;
      o_clip_r    <= (res_start_r && !res_blank_r) ? ram_rdata : '0;
      o_speaker_r <= speaker_r;
      o_ok_r      <= res_ok_r;
      o_ev_r      <= res_ev_r;
    end
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_play_start = o_start_r;
  assign out_play_clip  = o_clip_r;
  assign out_play_blank = o_blank_r;
  assign out_speaker_on = o_speaker_r;
  assign out_push_ok    = o_ok_r;
  assign out_evicted    = o_ev_r;

endmodule
